[hdl/dq_pkg.sv]
// Shared types, codes and ring arithmetic for the double-ended queue.
package dq_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = IDX_W + 1;
   localparam int DATA_W = 32;

   localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
   localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
   localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
   localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
   localparam logic [2:0] FUNC_READ_FWD   = 3'd4;
   localparam logic [2:0] FUNC_READ_BWD   = 3'd5;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]               func;
      logic signed [DATA_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_value;
      logic [1:0]               status;
      logic                     last_of_run;
   } rsp_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic       push;        // write one entry, grow the queue
      logic       pop;         // read one entry, shrink the queue
      logic       scan_start;  // read the first entry of a readout
      logic       scan_next;   // read the following entry of a readout
      logic       rear;        // back end / backward direction
      logic       load;        // load the output register
      logic       use_data;    // output value comes from the store
      logic [1:0] stat;
      logic       last;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic empty;
      logic full;
      logic out_free;
      logic scan_last;
   } st_type;

   // Reduce a value below 2*DEPTH into 0..DEPTH-1.
   function automatic logic [IDX_W-1:0] ring_wrap(input logic [SUM_W-1:0] a);
      logic [SUM_W-1:0] r;
      r = (a >= SUM_W'(DEPTH)) ? a - SUM_W'(DEPTH) : a;
      return r[IDX_W-1:0];
   endfunction

endpackage

[hdl/double_ended_queue.sv]
// Top level of the double-ended queue: controller, datapath and checks.
//
// Usage:
//   req channel: one beat carries a function code and a push value. Codes
//   push front, push back, pop front, pop back, read forward and read
//   backward; the two unused codes are taken and dropped with no result.
//   rsp channel: one beat per result, carrying the value, a status (ok,
//   empty, full) and last_of_run on the final beat caused by a request.
// Sequencing and throughput:
//   A push's beat is valid in the next cycle; one push is taken per
//   cycle while the receiver takes each beat. A pop reads the entry
//   store's registered read port, then loads the output register. A
//   readout of N entries gives N beats after a read start, one per cycle
//   as each is taken; requests are held off until the last is loaded.
// Reset:
//   The queue comes out empty with front index zero; store contents are
//   not cleared and are only ever read after being written.
// Stall:
//   When rsp_ready is low the output register holds its beat, the store
//   read data holds, and req_ready stays low until the beat is taken.
module double_ended_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  dq_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output dq_pkg::rsp_type rsp_data
);
   import dq_pkg::*;

   cmd_type cmd;
   st_type  st;

   // Decode and sequence.
   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   // Pointers, store and output beat register.
   dq_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .push_value (req_data.push_value),
      .st         (st),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // Never grow a full queue.
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !st.full)
      else $error("push issued into a full queue");

   // Never read from an empty queue.
   a_read_not_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop || cmd.scan_start) |-> !st.empty)
      else $error("read issued on an empty queue");

   // Never overwrite a beat the receiver has not taken.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid || rsp_ready))
      else $error("output beat overwritten");

   // A store read is always followed by its beat being loaded or held.
   a_read_then_load: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop || cmd.scan_start) |=> (cmd.load || (rsp_valid && !rsp_ready)))
      else $error("store read not followed by output load");

   // At most one store or pointer command at a time.
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.push, cmd.pop, cmd.scan_start, cmd.scan_next}) <= 1)
      else $error("conflicting datapath commands");

endmodule

[hdl/dq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dq_ram #(
   parameter  int WIDTH = 32,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/dq_dpath.sv]
// Datapath: ring pointers, entry store and output register.
module dq_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  dq_pkg::cmd_type                 cmd,
   input  logic signed [dq_pkg::DATA_W-1:0] push_value,
   output dq_pkg::st_type                  st,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output dq_pkg::rsp_type                 rsp_data
);
   import dq_pkg::*;

   logic [IDX_W-1:0]  front_ff, front_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  offset_ff, offset_in;
   logic              dir_ff, dir_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [CNT_W-1:0]  cnt_dec;
   logic [IDX_W-1:0]  cnt_m1;
   logic [IDX_W-1:0]  front_dec, front_inc, back_pos, last_pos, offset_nx;
   logic              wr_en, rd_en;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   logic [DATA_W-1:0] rd_data;

   assign cnt_dec   = count_ff - CNT_W'(1);
   assign cnt_m1    = cnt_dec[IDX_W-1:0];
   assign front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - IDX_W'(1);
   assign front_inc = ring_wrap(SUM_W'(front_ff) + SUM_W'(1));
   assign back_pos  = ring_wrap(SUM_W'(front_ff) + SUM_W'(count_ff));
   assign last_pos  = ring_wrap(SUM_W'(front_ff) + SUM_W'(cnt_m1));
   assign offset_nx = dir_ff ? offset_ff - IDX_W'(1) : offset_ff + IDX_W'(1);

   assign st.empty     = (count_ff == '0);
   assign st.full      = (count_ff == CNT_W'(DEPTH));
   assign st.out_free  = !rsp_valid_ff || rsp_ready;
   assign st.scan_last = dir_ff ? (offset_ff == '0) : (offset_ff == cnt_m1);

   assign wr_en   = cmd.push;
   assign wr_addr = cmd.rear ? back_pos : front_dec;
   assign rd_en   = cmd.pop || cmd.scan_start || cmd.scan_next;

   always_comb begin
      if (cmd.pop || cmd.scan_start) begin
         rd_addr = cmd.rear ? last_pos : front_ff;
      end else begin
         rd_addr = ring_wrap(SUM_W'(front_ff) + SUM_W'(offset_nx));
      end
   end

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      offset_in = offset_ff;
      dir_in    = dir_ff;
      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
         if (!cmd.rear) front_in = front_dec;
      end
      if (cmd.pop) begin
         count_in = cnt_dec;
         if (!cmd.rear) front_in = front_inc;
      end
      if (cmd.scan_start) begin
         dir_in    = cmd.rear;
         offset_in = cmd.rear ? cnt_m1 : '0;
      end
      if (cmd.scan_next) begin
         offset_in = offset_nx;
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.out_value   = cmd.use_data ? $signed(rd_data) : '0;
         rsp_in.status      = cmd.stat;
         rsp_in.last_of_run = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         offset_ff    <= '0;
         dir_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         offset_ff    <= offset_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   dq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (push_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hdl/dq_ctrl.sv]
// Controller: decodes requests and sequences pops and readouts.
module dq_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [2:0]      req_func,
   output logic            req_ready,
   input  dq_pkg::st_type  st,
   output dq_pkg::cmd_type cmd
);
   import dq_pkg::*;

   typedef enum logic {S_IDLE, S_DATA} state_type;

   state_type state_ff, state_in;
   logic      scan_ff, scan_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      scan_in   = scan_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = st.out_free;
            if (req_valid && st.out_free) begin
               cmd.rear = (req_func == FUNC_PUSH_BACK) || (req_func == FUNC_POP_BACK) ||
                          (req_func == FUNC_READ_BWD);
               case (req_func) inside
                  FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
                     cmd.load = 1'b1;
                     cmd.last = 1'b1;
                     if (st.full) begin
                        cmd.stat = STATUS_FULL;
                     end else begin
                        cmd.push = 1'b1;
                        cmd.stat = STATUS_OK;
                     end
                  end
                  FUNC_POP_FRONT, FUNC_POP_BACK: begin
                     if (st.empty) begin
                        cmd.load = 1'b1;
                        cmd.last = 1'b1;
                        cmd.stat = STATUS_EMPTY;
                     end else begin
                        cmd.pop  = 1'b1;
                        state_in = S_DATA;
                        scan_in  = 1'b0;
                     end
                  end
                  FUNC_READ_FWD, FUNC_READ_BWD: begin
                     if (st.empty) begin
                        cmd.load = 1'b1;
                        cmd.last = 1'b1;
                        cmd.stat = STATUS_EMPTY;
                     end else begin
                        cmd.scan_start = 1'b1;
                        state_in       = S_DATA;
                        scan_in        = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DATA: begin
            if (st.out_free) begin
               cmd.load     = 1'b1;
               cmd.use_data = 1'b1;
               cmd.stat     = STATUS_OK;
               cmd.last     = !scan_ff || st.scan_last;
               if (scan_ff && !st.scan_last) begin
                  cmd.scan_next = 1'b1;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         scan_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
      end
   end

endmodule

[sim/tb_double_ended_queue.sv]
// Self-checking testbench for the double-ended queue: directed table, then random traffic.
module tb_double_ended_queue;
   import dq_pkg::*;

   // The two function codes the block takes and drops without a result.
   localparam logic [2:0] FUNC_UNUSED_A = 3'd6;
   localparam logic [2:0] FUNC_UNUSED_B = 3'd7;

   localparam int RANDOM_ITEMS = 215;
   localparam int TAIL_ITEMS   = 40;     // final stretch with no idling on either side
   localparam int HOLD_CYCLES  = 80;     // long receiver hold-off
   localparam int SETTLE_CYCLES = 20;
   localparam int LIMIT_CYCLES = 400000;

   localparam rsp_type RSP_PUSHED = '{out_value: '0, status: STATUS_OK,    last_of_run: 1'b1};
   localparam rsp_type RSP_EMPTY  = '{out_value: '0, status: STATUS_EMPTY, last_of_run: 1'b1};
   localparam rsp_type RSP_FULL   = '{out_value: '0, status: STATUS_FULL,  last_of_run: 1'b1};

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   double_ended_queue i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // Mirror of the queue contents, kept in step with every accepted request beat.
   logic [DATA_W-1:0] mirror_entry [DEPTH];
   int                mirror_front = 0;
   int                mirror_count = 0;

   // Response beats still owed by the block, oldest first.
   rsp_type results_due [$];
   int      faults = 0;

   bit steady_tail = 1'b0;      // set in the last part of the run: no gaps, no stalls
   bit hold_off_request = 1'b0; // sender asks the receiver for one long hold-off

   // Directed stimulus. A row is repeated reps times with the push value stepping by one;
   // where typed is set the row carries its own single expected beat.
   typedef struct {
      logic [2:0]        func;
      logic [DATA_W-1:0] value;
      int                reps;
      bit                typed;
      rsp_type           want;
   } drill_row_type;

   localparam int DRILL_ROWS = 19;
   drill_row_type drill_plan [DRILL_ROWS] = '{
      // empty queue straight out of reset
      '{FUNC_POP_FRONT,  32'h0000_0000, 1,  1'b1, RSP_EMPTY},
      '{FUNC_POP_BACK,   32'hFFFF_FFFF, 1,  1'b1, RSP_EMPTY},
      '{FUNC_READ_FWD,   32'h1234_5678, 1,  1'b1, RSP_EMPTY},
      '{FUNC_READ_BWD,   32'h8765_4321, 1,  1'b1, RSP_EMPTY},
      // extreme values at both ends; front index wraps below zero
      '{FUNC_PUSH_FRONT, 32'h7FFF_FFFF, 1,  1'b1, RSP_PUSHED},
      '{FUNC_PUSH_BACK,  32'h8000_0000, 1,  1'b1, RSP_PUSHED},
      '{FUNC_PUSH_FRONT, 32'hFFFF_FFFF, 1,  1'b1, RSP_PUSHED},
      '{FUNC_PUSH_BACK,  32'h0000_0000, 1,  1'b1, RSP_PUSHED},
      // unused codes: no beat at all; then read both ways and pop both ends
      '{FUNC_UNUSED_A,   32'hDEAD_BEEF, 1,  1'b0, RSP_PUSHED},
      '{FUNC_UNUSED_B,   32'h0F0F_0F0F, 1,  1'b0, RSP_PUSHED},
      '{FUNC_READ_FWD,   32'h0000_0000, 1,  1'b0, RSP_PUSHED},
      '{FUNC_READ_BWD,   32'h0000_0000, 1,  1'b0, RSP_PUSHED},
      '{FUNC_POP_FRONT,  32'h0000_0000, 1,  1'b1,
        '{out_value: 32'hFFFF_FFFF, status: STATUS_OK, last_of_run: 1'b1}},
      '{FUNC_POP_BACK,   32'h0000_0000, 1,  1'b1,
        '{out_value: 32'h0000_0000, status: STATUS_OK, last_of_run: 1'b1}},
      // fill up across the ring boundary, then bounce off the full queue
      '{FUNC_PUSH_BACK,  32'h5A5A_0000, 14, 1'b1, RSP_PUSHED},
      '{FUNC_PUSH_FRONT, 32'h1111_1111, 1,  1'b1, RSP_FULL},
      '{FUNC_PUSH_BACK,  32'h2222_2222, 1,  1'b1, RSP_FULL},
      '{FUNC_READ_FWD,   32'h0000_0000, 1,  1'b0, RSP_PUSHED},
      '{FUNC_READ_BWD,   32'h0000_0000, 1,  1'b0, RSP_PUSHED}
   };

   function automatic rsp_type make_beat(logic [DATA_W-1:0] value, logic [1:0] status,
                                         logic last);
      rsp_type beat;
      beat.out_value   = value;
      beat.status      = status;
      beat.last_of_run = last;
      return beat;
   endfunction

   // Work out the beats one request causes and advance the mirror.
   task automatic predict_deque(input req_type req, ref rsp_type beats[$]);
      int slot;
      int offset;
      beats = {};
      case (req.func)
         FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
            if (mirror_count == DEPTH) begin
               beats.push_back(make_beat('0, STATUS_FULL, 1'b1));
            end else begin
               if (req.func == FUNC_PUSH_FRONT) begin
                  mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
                  slot = mirror_front;
               end else begin
                  slot = (mirror_front + mirror_count) % DEPTH;
               end
               mirror_entry[slot] = req.push_value;
               mirror_count++;
               beats.push_back(make_beat('0, STATUS_OK, 1'b1));
            end
         end
         FUNC_POP_FRONT, FUNC_POP_BACK: begin
            if (mirror_count == 0) begin
               beats.push_back(make_beat('0, STATUS_EMPTY, 1'b1));
            end else begin
               if (req.func == FUNC_POP_FRONT) begin
                  slot = mirror_front;
                  mirror_front = (mirror_front + 1) % DEPTH;
               end else begin
                  slot = (mirror_front + mirror_count - 1) % DEPTH;
               end
               mirror_count--;
               beats.push_back(make_beat(mirror_entry[slot], STATUS_OK, 1'b1));
            end
         end
         FUNC_READ_FWD, FUNC_READ_BWD: begin
            if (mirror_count == 0) begin
               beats.push_back(make_beat('0, STATUS_EMPTY, 1'b1));
            end else begin
               for (int i = 0; i < mirror_count; i++) begin
                  offset = (req.func == FUNC_READ_FWD) ? i : mirror_count - 1 - i;
                  slot = (mirror_front + offset) % DEPTH;
                  beats.push_back(make_beat(mirror_entry[slot], STATUS_OK,
                                            i == mirror_count - 1));
               end
            end
         end
         default: begin
            // unused codes: drop, no beat
         end
      endcase
   endtask

   // Offer one request beat from a falling edge, hold it until taken, and record
   // what it owes. Returns at the falling edge after acceptance.
   task automatic offer_request(input req_type req, input bit typed, input rsp_type want);
      rsp_type beats [$];
      // random gap before the beat, dropping valid for a burst
      if (!steady_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req;
      do @(posedge clock); while (!req_ready);
      predict_deque(req, beats);
      if (typed) begin
         results_due.push_back(want);
      end else begin
         foreach (beats[i]) results_due.push_back(beats[i]);
      end
      @(negedge clock);
   endtask

   // Drop valid and wait at the falling edge until every owed beat has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (results_due.size() != 0);
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Random request; the mix leans toward pushes while filling and pops while emptying,
   // so the queue swings between empty and full.
   function automatic req_type pick_request(bit filling);
      req_type req;
      int      roll;
      roll = $urandom_range(0, 99);
      req.push_value = pick_value();
      if (roll < (filling ? 55 : 25)) begin
         req.func = $urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
      end else if (roll < (filling ? 80 : 75)) begin
         req.func = $urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
      end else if (roll < 94) begin
         req.func = $urandom_range(0, 1) ? FUNC_READ_BWD : FUNC_READ_FWD;
      end else begin
         req.func = $urandom_range(0, 1) ? FUNC_UNUSED_B : FUNC_UNUSED_A;
      end
      return req;
   endfunction

   // Sender: reset, directed table, random traffic, then drain and report.
   initial begin
      req_type req;
      int      counted;
      int      k;
      counted = 0;
      k = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (drill_plan[r]) begin
         for (int rep = 0; rep < drill_plan[r].reps; rep++) begin
            req.func       = drill_plan[r].func;
            req.push_value = drill_plan[r].value + rep;
            offer_request(req, drill_plan[r].typed, drill_plan[r].want);
         end
      end
      drain_results();

      while (counted < RANDOM_ITEMS) begin
         steady_tail = (counted >= RANDOM_ITEMS - TAIL_ITEMS);
         // ask for the long receiver hold-off while beats keep coming
         if (k == 100) hold_off_request = 1'b1;
         // pause the sender once until the block has nothing left to say
         if (k == 170) drain_results();
         req = pick_request(((k / 40) % 2) == 0);
         offer_request(req, 1'b0, RSP_PUSHED);
         if (req.func != FUNC_UNUSED_A && req.func != FUNC_UNUSED_B) counted++;
         k++;
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (faults == 0 && results_due.size() == 0) begin
         $display("tb_double_ended_queue passed");
      end else begin
         $display("tb_double_ended_queue failed");
      end
      $finish;
   end

   // Receiver: drive rsp_ready at the falling edge in bursts of stalls, with one long
   // hold-off on request so the output register fills and req_ready drops.
   initial begin
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_off_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_request = 1'b0;
         end else if (!steady_tail && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Checker: compare every accepted response beat with the oldest owed beat.
   rsp_type owed;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            $display("%0t: expected no beat, got value %h status %0d last %b", $time,
                     rsp_data.out_value, rsp_data.status, rsp_data.last_of_run);
            faults++;
         end else begin
            owed = results_due.pop_front();
            if (rsp_data.out_value !== owed.out_value) begin
               $display("%0t: out_value expected %h got %h", $time,
                        owed.out_value, rsp_data.out_value);
               faults++;
            end
            if (rsp_data.status !== owed.status) begin
               $display("%0t: status expected %0d got %0d", $time,
                        owed.status, rsp_data.status);
               faults++;
            end
            if (rsp_data.last_of_run !== owed.last_of_run) begin
               $display("%0t: last_of_run expected %b got %b", $time,
                        owed.last_of_run, rsp_data.last_of_run);
               faults++;
            end
         end
      end
   end

   // Watchdog: end a hung run.
   initial begin
      #(LIMIT_CYCLES * 20);
      $display("tb_double_ended_queue failed");
      $finish;
   end

endmodule
